>>> design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and helpers shared by the barometric compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] P_C1      = 32'd3038;
  localparam logic [31:0] P_C2      = 32'd7357;
  localparam logic [31:0] P_C3      = 32'd3791;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [31:0] B7_HALF   = 32'h8000_0000;
  localparam logic [31:0] T_ROUND   = 32'd8;
  localparam logic [16:0] PRESS_MAX = 17'h1_FFFF;

  typedef enum logic [2:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4,
    CFG_OSS     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [18:0] raw_press;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temp_tenths;
    logic [16:0]        press_pa;
    logic               divide_error;
    logic               range_error;
  } out_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = 32'($signed(v));
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

endpackage

`default_nettype wire

>>> design/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Throughput: one request per cycle while the output does not stall; two 32-stage
// dividers set the depth. A stall at the output freezes the whole pipeline and
// holds the input off. Reset clears all valid bits and the coefficient registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_sensor_compensation (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bsc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bsc_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  import bsc_pkg::*;

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_AC1_AC2: ac12_q <= cfg_data_i;
        CFG_AC3_AC4: ac34_q <= cfg_data_i;
        CFG_AC5_AC6: ac56_q <= cfg_data_i;
        CFG_B1_B2:   b12_q  <= cfg_data_i;
        CFG_MC_MD:   mcmd_q <= cfg_data_i;
        CFG_OSS:     oss_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign ac1 = sx16(ac12_q[31:16]);
  assign ac2 = sx16(ac12_q[15:0]);
  assign ac3 = sx16(ac34_q[31:16]);
  assign ac4 = {16'd0, ac34_q[15:0]};
  assign ac5 = {16'd0, ac56_q[31:16]};
  assign ac6 = {16'd0, ac56_q[15:0]};
  assign b1  = sx16(b12_q[31:16]);
  assign b2  = sx16(b12_q[15:0]);
  assign mc  = sx16(mcmd_q[31:16]);
  assign md  = sx16(mcmd_q[15:0]);

  // global advance: the output register is the last stage
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        neg;
    logic        dz;
  } d1_side_t;

  typedef struct packed {
    logic [15:0] t;
    logic        dz;
    logic        dbl;
  } d2_side_t;

  localparam int unsigned D1SW = $bits(d1_side_t);
  localparam int unsigned D2SW = $bits(d2_side_t);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v11_q, v12_q, v13_q, v14_q, v15_q;
  logic d1_vo, d2_vo;

  // temperature front end
  logic [31:0] p1_q;
  logic [18:0] up1_q, up2_q;
  logic [31:0] x1_2_q, den2_q;
  logic [31:0] n3_q, d3_q;
  d1_side_t    s3_q;
  logic [31:0] n2, mn2, md2;

  always_comb begin
    n2  = mc << 11;
    mn2 = n2[31] ? 32'd0 - n2 : n2;
    md2 = den2_q[31] ? 32'd0 - den2_q : den2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q   <= (32'(in_data_i.raw_temp) - ac6) * ac5;
      up1_q  <= in_data_i.raw_press;
      x1_2_q <= asr32(p1_q, 5'd15);
      den2_q <= asr32(p1_q, 5'd15) + md;
      up2_q  <= up1_q;
      n3_q   <= mn2;
      d3_q   <= md2;
      s3_q   <= '{x1: x1_2_q, up: up2_q, neg: n2[31] ^ den2_q[31], dz: den2_q == '0};
    end
  end

  logic [31:0] q1;
  d1_side_t    s1o;

  bsc_udiv #(.W(DATA_W), .SW(D1SW)) u_div_t (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v3_q),
    .num_i  (n3_q),
    .den_i  (d3_q),
    .side_i (s3_q),
    .valid_o(d1_vo),
    .quot_o (q1),
    .side_o (s1o)
  );

  // between the dividers: b5 through b4 and b7
  logic [31:0] b5_4_q, b6_5_q, sq6_q, pa2_6_q, pa3_6_q;
  logic [31:0] pb2_7_q, pb1_7_q, pa2_7_q, pa3_7_q;
  logic [31:0] b3_8_q, x3b_8_q, b4_9_q, b7_9_q, b6sq7;
  logic [15:0] t5_q, t6_q, t7_q, t8_q, t9_q;
  logic [18:0] up4_q, up5_q, up6_q, up7_q, up8_q;
  logic        dz4_q, dz5_q, dz6_q, dz7_q, dz8_q, dz9_q;
  logic [31:0] x3a8, b3pre8, b5r, t5w;

  assign b6sq7  = asr32(sq6_q, 5'd12);
  assign x3a8   = asr32(pb2_7_q, 5'd11) + asr32(pa2_7_q, 5'd11);
  assign b3pre8 = (((ac1 << 2) + x3a8) << oss_q) + 32'd2;
  assign b5r    = b5_4_q + T_ROUND;
  assign t5w    = asr32(b5r, 5'd4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b5_4_q  <= s1o.x1 + (s1o.neg ? 32'd0 - q1 : q1);
      up4_q   <= s1o.up;
      dz4_q   <= s1o.dz;
      t5_q    <= t5w[15:0];
      b6_5_q  <= b5_4_q - B6_OFFSET;
      up5_q   <= up4_q;
      dz5_q   <= dz4_q;
      sq6_q   <= b6_5_q * b6_5_q;
      pa2_6_q <= ac2 * b6_5_q;
      pa3_6_q <= ac3 * b6_5_q;
      t6_q    <= t5_q;
      up6_q   <= up5_q;
      dz6_q   <= dz5_q;
      pb2_7_q <= b2 * b6sq7;
      pb1_7_q <= b1 * b6sq7;
      pa2_7_q <= pa2_6_q;
      pa3_7_q <= pa3_6_q;
      t7_q    <= t6_q;
      up7_q   <= up6_q;
      dz7_q   <= dz6_q;
      b3_8_q  <= asr32(b3pre8, 5'd2);
      x3b_8_q <= asr32(asr32(pa3_7_q, 5'd13) + asr32(pb1_7_q, 5'd16) + 32'd2, 5'd2);
      t8_q    <= t7_q;
      up8_q   <= up7_q;
      dz8_q   <= dz7_q;
      b4_9_q  <= (ac4 * (x3b_8_q + B4_BIAS)) >> 15;
      b7_9_q  <= (32'(up8_q) - b3_8_q) * (B7_SCALE >> oss_q);
      t9_q    <= t8_q;
      dz9_q   <= dz8_q;
    end
  end

  logic        b7_low;
  d2_side_t    s2i, s2o;
  logic [31:0] q2;

  assign b7_low = b7_9_q < B7_HALF;
  assign s2i    = '{t: t9_q, dz: dz9_q || (b4_9_q == '0), dbl: !b7_low};

  bsc_udiv #(.W(DATA_W), .SW(D2SW)) u_div_p (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v9_q),
    .num_i  (b7_low ? b7_9_q << 1 : b7_9_q),
    .den_i  (b4_9_q),
    .side_i (s2i),
    .valid_o(d2_vo),
    .quot_o (q2),
    .side_o (s2o)
  );

  // pressure back end
  logic [31:0] p11_q, p12_q, p13_q, p14_q, sq12_q, m2_12_q, m2_13_q, m1_13_q;
  logic [15:0] t11_q, t12_q, t13_q, t14_q;
  logic        dz11_q, dz12_q, dz13_q, dz14_q;
  logic [31:0] a12, sum14;
  out_t        out_d, out_q;

  assign a12   = asr32(p11_q, 5'd8);
  assign sum14 = asr32(m1_13_q, 5'd16) + asr32(m2_13_q, 5'd16) + P_C3;

  always_comb begin
    out_d = '0;
    if (dz14_q) begin
      out_d.divide_error = 1'b1;
    end else begin
      out_d.temp_tenths = $signed(t14_q);
      if (p14_q[31]) begin
        out_d.range_error = 1'b1;
      end else if (p14_q > 32'(PRESS_MAX)) begin
        out_d.press_pa    = PRESS_MAX;
        out_d.range_error = 1'b1;
      end else begin
        out_d.press_pa = p14_q[16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p11_q   <= s2o.dbl ? q2 << 1 : q2;
      t11_q   <= s2o.t;
      dz11_q  <= s2o.dz;
      sq12_q  <= a12 * a12;
      m2_12_q <= (32'd0 - P_C2) * p11_q;
      p12_q   <= p11_q;
      t12_q   <= t11_q;
      dz12_q  <= dz11_q;
      m1_13_q <= sq12_q * P_C1;
      m2_13_q <= m2_12_q;
      p13_q   <= p12_q;
      t13_q   <= t12_q;
      dz13_q  <= dz12_q;
      p14_q   <= p13_q + asr32(sum14, 5'd4);
      t14_q   <= t13_q;
      dz14_q  <= dz13_q;
      out_q   <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q} <= '0;
      {v11_q, v12_q, v13_q, v14_q, v15_q} <= '0;
    end else if (adv) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= d1_vo;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v11_q <= d2_vo;
      v12_q <= v11_q;
      v13_q <= v12_q;
      v14_q <= v13_q;
      v15_q <= v14_q;
    end
  end

  assign out_valid_o = v15_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> design/bsc_udiv.sv
// ----------------------------------------------------------------------------
// bsc_udiv
// Unsigned restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_udiv #(
  parameter int unsigned W  = bsc_pkg::DATA_W,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quot_o,
  output logic [SW-1:0] side_o
);

  typedef struct packed {
    logic          v;
    logic [SW-1:0] s;
    logic [W-1:0]  d;
    logic [W-1:0]  n;
    logic [W-1:0]  r;
    logic [W-1:0]  q;
  } stage_t;

  stage_t st_in;
  stage_t st_q [W];

  assign st_in = '{v: valid_i, s: side_i, d: den_i, n: num_i, r: '0, q: '0};

  for (genvar i = 0; i < W; i++) begin : g_stage
    stage_t   src;
    stage_t   st_d;
    logic [W:0] sh;
    logic [W:0] diff;

    if (i == 0) begin : g_first
      assign src = st_in;
    end else begin : g_next
      assign src = st_q[i-1];
    end

    always_comb begin
      sh        = {src.r, src.n[W-1]};
      diff      = sh - {1'b0, src.d};
      st_d      = src;
      st_d.n    = src.n << 1;
      // trial subtract: keep the difference when it did not borrow
      st_d.r    = diff[W] ? sh[W-1:0] : diff[W-1:0];
      st_d.q    = {src.q[W-2:0], ~diff[W]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i].v <= 1'b0;
      end else if (en_i) begin
        st_q[i] <= st_d;
      end
    end
  end

  assign valid_o = st_q[W-1].v;
  assign quot_o  = st_q[W-1].q;
  assign side_o  = st_q[W-1].s;

endmodule

`default_nettype wire

>>> design/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for the barometric compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_stall_o,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  bsc_pkg::out_t  out_data_o
);
  import bsc_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a stalled output holds the input off
  a_back_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  a_div_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_error |->
      out_data_o.press_pa == '0 && out_data_o.temp_tenths == '0 &&
      !out_data_o.range_error)
    else $error("divide error with nonzero fields");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |->
      out_data_o.press_pa == '0 || out_data_o.press_pa == PRESS_MAX)
    else $error("range error without saturated pressure");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire

>>> dv/tb_barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation
// Self-checking bench for the pressure/temperature compensation pipeline.
// A table of directed requests runs first, then random requests under several
// coefficient settings. Each result is checked against its table value or an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_barometric_sensor_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned TAIL_CYCLES    = 100;

  typedef logic [31:0] coeff_set_t [6];

  typedef struct {
    int unsigned set_idx;
    in_t         req;
    bit          typed;
    out_t        want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid    = 1'b0;
  logic       in_stall;
  in_t        in_data     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  out_t       out_data;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  cfg_reg_e   cfg_index   = CFG_AC1_AC2;
  logic [31:0] cfg_data   = '0;

  // shadow copy of the coefficient registers
  logic [31:0] sh_ac1_ac2, sh_ac3_ac4, sh_ac5_ac6, sh_b1_b2, sh_mc_md, sh_oss;

  out_t        pending_q[$];
  int unsigned n_errors   = 0;
  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_div_err  = 0;
  int unsigned n_rng_err  = 0;
  bit          quiet      = 1'b0;
  int unsigned hold_reqs  = 0;
  int unsigned hold_done  = 0;
  int unsigned hold_left  = 0;
  int unsigned idle_cyc   = 0;

  barometric_sensor_compensation i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] ashr(input logic [31:0] v, input int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed divide, truncating toward zero, wrapping on overflow
  function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn, mdv, q;
    mn  = n[31] ? 32'd0 - n : n;
    mdv = d[31] ? 32'd0 - d : d;
    q   = mn / mdv;
    return (n[31] != d[31]) ? 32'd0 - q : q;
  endfunction

  function automatic out_t compensate(input in_t d);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, b6sq, b3, b4, b7, p, t;
    int unsigned oss;
    out_t r;
    oss = sh_oss[1:0];
    ac1 = sext16(sh_ac1_ac2[31:16]);
    ac2 = sext16(sh_ac1_ac2[15:0]);
    ac3 = sext16(sh_ac3_ac4[31:16]);
    ac4 = {16'd0, sh_ac3_ac4[15:0]};
    ac5 = {16'd0, sh_ac5_ac6[31:16]};
    ac6 = {16'd0, sh_ac5_ac6[15:0]};
    b1  = sext16(sh_b1_b2[31:16]);
    b2  = sext16(sh_b1_b2[15:0]);
    mc  = sext16(sh_mc_md[31:16]);
    md  = sext16(sh_mc_md[15:0]);
    ut  = {16'd0, d.raw_temp};
    up  = {13'd0, d.raw_press};
    r = '0;
    r.divide_error = 1'b1;

    x1  = ashr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 32'd0) return r;
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    t  = ashr(b5 + T_ROUND, 4);

    b6   = b5 - B6_OFFSET;
    b6sq = ashr(b6 * b6, 12);
    x1   = ashr(b2 * b6sq, 11);
    x2   = ashr(ac2 * b6, 11);
    x3   = x1 + x2;
    b3   = ashr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1   = ashr(ac3 * b6, 13);
    x2   = ashr(b1 * b6sq, 16);
    x3   = ashr(x1 + x2 + 32'd2, 2);
    b4   = (ac4 * (x3 + B4_BIAS)) >> 15;
    if (b4 == 32'd0) return r;
    b7 = (up - b3) * (B7_SCALE >> oss);
    if (b7 < B7_HALF) p = (b7 * 32'd2) / b4;
    else              p = (b7 / b4) * 32'd2;

    x1 = ashr(p, 8) * ashr(p, 8);
    x1 = ashr(x1 * P_C1, 16);
    x2 = ashr((32'd0 - P_C2) * p, 16);
    p  = p + ashr(x1 + x2 + P_C3, 4);

    r.divide_error = 1'b0;
    r.temp_tenths  = t[15:0];
    if (p[31]) begin
      r.press_pa    = '0;
      r.range_error = 1'b1;
    end else if (p > {15'd0, PRESS_MAX}) begin
      r.press_pa    = PRESS_MAX;
      r.range_error = 1'b1;
    end else begin
      r.press_pa = p[16:0];
    end
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    n_errors++;
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_q.size() == 0) begin
      report("unexpected result", 32'(got), 32'd0);
      return;
    end
    want = pending_q.pop_front();
    n_checked++;
    if (want.divide_error) n_div_err++;
    if (want.range_error) n_rng_err++;
    if (got.temp_tenths !== want.temp_tenths)
      report("temp_tenths", 32'(got.temp_tenths), 32'(want.temp_tenths));
    if (got.press_pa !== want.press_pa)
      report("press_pa", 32'(got.press_pa), 32'(want.press_pa));
    if (got.divide_error !== want.divide_error)
      report("divide_error", 32'(got.divide_error), 32'(want.divide_error));
    if (got.range_error !== want.range_error)
      report("range_error", 32'(got.range_error), 32'(want.range_error));
  endtask

  // result side: random stall, long holds on request from the stimulus
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_reqs != hold_done) begin
        hold_done <= hold_reqs;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 36);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic load_coeffs(input coeff_set_t w);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= cfg_reg_e'(i);
      cfg_data  <= w[i];
      do @(posedge clk_i); while (!cfg_ready);
      case (cfg_reg_e'(i))
        CFG_AC1_AC2: sh_ac1_ac2 = w[i];
        CFG_AC3_AC4: sh_ac3_ac4 = w[i];
        CFG_AC5_AC6: sh_ac5_ac6 = w[i];
        CFG_B1_B2:   sh_b1_b2   = w[i];
        CFG_MC_MD:   sh_mc_md   = w[i];
        CFG_OSS:     sh_oss     = w[i] & 32'd3;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input in_t d, input bit typed, input out_t want);
    int unsigned gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 36) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk_i); while (in_stall);
    pending_q.push_back(typed ? want : compensate(d));
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_t random_request();
    in_t d;
    if ($urandom_range(9) < 7) begin
      d.raw_temp  = 16'($urandom_range(20000, 40000));
      d.raw_press = 19'($urandom_range(15000, 45000) << sh_oss[1:0]);
    end else begin
      d.raw_temp  = 16'($urandom);
      d.raw_press = 19'($urandom);
    end
    return d;
  endfunction

  function automatic logic [15:0] nudge(input logic [15:0] v);
    return v + 16'($urandom_range(400)) - 16'd200;
  endfunction

  coeff_set_t fixed_sets [6];
  dir_row_t   dir_rows [$];

  function automatic dir_row_t row(input int unsigned s, input logic [15:0] ut,
                                   input logic [18:0] up, input bit typed, input out_t want);
    dir_row_t r;
    r.set_idx       = s;
    r.req.raw_temp  = ut;
    r.req.raw_press = up;
    r.typed         = typed;
    r.want          = want;
    return r;
  endfunction

  initial begin
    out_t div_err, none, sheet;
    coeff_set_t cs;
    int unsigned cur_set;
    sh_ac1_ac2 = '0; sh_ac3_ac4 = '0; sh_ac5_ac6 = '0;
    sh_b1_b2 = '0; sh_mc_md = '0; sh_oss = '0;

    fixed_sets[0] = '{default: 32'd0};
    fixed_sets[1] = '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71,
                      32'h182E_0004, 32'hDDF9_0B34, 32'd0};
    fixed_sets[2] = '{32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71,
                      32'h182E_0004, 32'hDDF9_0B34, 32'd0};
    fixed_sets[3] = '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71,
                      32'h182E_0004, 32'hDDF9_0B34, 32'd3};
    fixed_sets[4] = '{default: 32'hFFFF_FFFF};
    fixed_sets[5] = '{32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_8000, 32'h8000_7FFF, 32'd2};

    div_err = '0; div_err.divide_error = 1'b1;
    none    = '0;
    sheet   = '0; sheet.temp_tenths = 16'sd150; sheet.press_pa = 17'd69964;

    // zero coefficients after reset: temperature divisor is zero
    dir_rows.push_back(row(0, 16'h0000, 19'h00000, 1, div_err));
    dir_rows.push_back(row(0, 16'hFFFF, 19'h7FFFF, 1, div_err));
    dir_rows.push_back(row(0, 16'h8000, 19'h40000, 1, div_err));
    // datasheet coefficients and worked example
    dir_rows.push_back(row(1, 16'd27898, 19'd23843, 1, sheet));
    dir_rows.push_back(row(1, 16'h0000, 19'h00000, 0, none));
    dir_rows.push_back(row(1, 16'hFFFF, 19'h7FFFF, 0, none));
    dir_rows.push_back(row(1, 16'h0000, 19'h7FFFF, 0, none));
    dir_rows.push_back(row(1, 16'hFFFF, 19'h00000, 0, none));
    dir_rows.push_back(row(1, 16'hAAAA, 19'h55555, 0, none));
    dir_rows.push_back(row(1, 16'h5555, 19'h2AAAA, 0, none));
    dir_rows.push_back(row(1, 16'd27898, 19'd0, 0, none));
    // ac4 zero: pressure divisor is zero
    dir_rows.push_back(row(2, 16'd27898, 19'd23843, 1, div_err));
    dir_rows.push_back(row(2, 16'hFFFF, 19'h7FFFF, 1, div_err));
    dir_rows.push_back(row(3, 16'd27898, 19'd190744, 0, none));
    dir_rows.push_back(row(3, 16'hFFFF, 19'h7FFFF, 0, none));
    dir_rows.push_back(row(4, 16'h0000, 19'h00000, 0, none));
    dir_rows.push_back(row(4, 16'hFFFF, 19'h7FFFF, 0, none));
    dir_rows.push_back(row(5, 16'd1234, 19'd12345, 0, none));
    dir_rows.push_back(row(5, 16'h7FFF, 19'h3FFFF, 0, none));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_set = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_idx != cur_set) begin
        wait_drained();
        cur_set = dir_rows[i].set_idx;
        load_coeffs(fixed_sets[cur_set]);
      end
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 4 || ph == 5) begin
        foreach (cs[k]) cs[k] = $urandom;
      end else begin
        cs = fixed_sets[1];
        for (int k = 0; k < 5; k++) cs[k] = {nudge(cs[k][31:16]), nudge(cs[k][15:0])};
        cs[5] = {30'($urandom_range(32'h3FFF_FFFF)), 2'(ph)};
      end
      load_coeffs(cs);
      quiet = (ph == 1);
      if (ph == 2) begin
        // hold results off long enough for the pipeline to back up
        quiet = 1'b1;
        hold_reqs++;
        for (int n = 0; n < 200; n++) send_request(random_request(), 0, none);
        quiet = 1'b0;
      end
      for (int n = 0; n < 205; n++) begin
        if (ph == 3 && n == 100) wait_drained();
        send_request(random_request(), 0, none);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked (%0d divide errors, %0d saturated)",
             n_sent, n_checked, n_div_err, n_rng_err);
    $display("coefficient settings: zero, datasheet, extremes, perturbed and random, oss 0..3");
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> barometric_sensor_compensation.f
design/bsc_pkg.sv
design/bsc_udiv.sv
design/barometric_sensor_compensation.sv
design/bsc_checker.sv
dv/tb_barometric_sensor_compensation.sv
